// ----- rtl/gpc_pkg.sv -----
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared constants, register word offsets and types of the GPIO pin controller.
// ----------------------------------------------------------------------------
package gpc_pkg;

   localparam int PIN_COUNT    = 54;
   localparam int FSEL_PER_WORD = 10;
   localparam int FSEL_WORDS   = (PIN_COUNT + FSEL_PER_WORD - 1) / FSEL_PER_WORD;

   // Bus access kinds
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Register word offsets (byte offset / 4)
   localparam logic [5:0] WORD_SET0    = 6'd7;
   localparam logic [5:0] WORD_SET1    = 6'd8;
   localparam logic [5:0] WORD_CLR0    = 6'd10;
   localparam logic [5:0] WORD_CLR1    = 6'd11;
   localparam logic [5:0] WORD_LEV0    = 6'd13;
   localparam logic [5:0] WORD_LEV1    = 6'd14;
   localparam logic [5:0] WORD_PUD     = 6'd37;
   localparam logic [5:0] WORD_PUDCLK0 = 6'd38;
   localparam logic [5:0] WORD_PUDCLK1 = 6'd39;

   // Function field that makes a pin drive
   localparam logic [2:0] FSEL_OUTPUT = 3'b001;

   // Pull control codes
   localparam logic [1:0] PULL_OFF = 2'd0;
   localparam logic [1:0] PULL_DN  = 2'd1;
   localparam logic [1:0] PULL_UP  = 2'd2;

   typedef struct packed {
      logic                 op;
      logic [5:0]           word_index;
      logic [31:0]          write_data;
      logic [PIN_COUNT-1:0] pad_levels;
   } access_type;

   typedef struct packed {
      logic [PIN_COUNT-1:0] drive;
      logic [PIN_COUNT-1:0] output_enable;
      logic [PIN_COUNT-1:0] pull_up;
      logic [PIN_COUNT-1:0] pull_dn;
   } pin_status_type;

   // Place a 32-bit word into the low or high half of a pin vector.
   function automatic logic [PIN_COUNT-1:0] word_to_pins(input logic [31:0] w,
                                                         input logic hi);
      logic [63:0] v;
      v = hi ? {w, 32'h0} : {32'h0, w};
      return v[PIN_COUNT-1:0];
   endfunction

   // Take the low or high 32 pins of a pin vector as a word.
   function automatic logic [31:0] pins_to_word(input logic [PIN_COUNT-1:0] pins,
                                                input logic hi);
      logic [63:0] v;
      v = 64'(pins);
      return hi ? v[63:32] : v[31:0];
   endfunction

endpackage

// ----- rtl/gpc_reg_file.sv -----
// ----------------------------------------------------------------------------
// gpc_reg_file
// Register state of the pin controller: function select, output latches,
// pull control and pull clock. Applies one access when enabled and shows the
// read word and the pin status as they stand after that access.
// ----------------------------------------------------------------------------
module gpc_reg_file (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  gpc_pkg::access_type          access,
   output logic [31:0]                  read_data,
   output gpc_pkg::pin_status_type      status
);
   import gpc_pkg::*;

   logic [2:0]           func_ff  [PIN_COUNT];
   logic [2:0]           func_in  [PIN_COUNT];
   logic [1:0]           pull_ff  [PIN_COUNT];
   logic [1:0]           pull_in  [PIN_COUNT];
   logic [PIN_COUNT-1:0] latch_ff, latch_in;
   logic [PIN_COUNT-1:0] pclk_ff, pclk_in;
   logic [1:0]           pud_ff, pud_in;

   logic                 wr;
   logic                 hi;
   logic [5:0]           idx;
   logic [PIN_COUNT-1:0] data_pins;
   logic [PIN_COUNT-1:0] half_mask;
   logic [PIN_COUNT-1:0] rise;

   assign wr        = enable && (access.op == OP_WRITE);
   assign idx       = access.word_index;
   assign hi        = (idx == WORD_SET1) || (idx == WORD_CLR1) ||
                      (idx == WORD_LEV1) || (idx == WORD_PUDCLK1);
   assign data_pins = word_to_pins(access.write_data, hi);
   assign half_mask = word_to_pins(32'hFFFF_FFFF, hi);

   // Next state
   always_comb begin
      func_in  = func_ff;
      pull_in  = pull_ff;
      latch_in = latch_ff;
      pclk_in  = pclk_ff;
      pud_in   = pud_ff;
      rise     = '0;

      if (wr) begin
         for (int p = 0; p < PIN_COUNT; p++) begin
            if (idx == 6'(p / FSEL_PER_WORD)) begin
               func_in[p] = access.write_data[3 * (p % FSEL_PER_WORD) +: 3];
            end
         end
         case (idx)
            WORD_SET0, WORD_SET1: latch_in = latch_ff | data_pins;
            WORD_CLR0, WORD_CLR1: latch_in = latch_ff & ~data_pins;
            WORD_PUD:             pud_in   = access.write_data[1:0];
            WORD_PUDCLK0, WORD_PUDCLK1: begin
               pclk_in = (pclk_ff & ~half_mask) | data_pins;
               rise    = pclk_in & ~pclk_ff;
            end
            default: ;
         endcase
         // latch the pull code into every pin whose clock bit rises
         for (int p = 0; p < PIN_COUNT; p++) begin
            if (rise[p]) begin
               pull_in[p] = pud_ff;
            end
         end
      end
   end

   // Read word, from the state before the access
   always_comb begin
      read_data = '0;
      if (access.op == OP_READ) begin
         for (int w = 0; w < FSEL_WORDS; w++) begin
            for (int i = 0; i < FSEL_PER_WORD; i++) begin
               if ((w * FSEL_PER_WORD + i < PIN_COUNT) && (idx == 6'(w))) begin
                  read_data[3 * i +: 3] = func_ff[w * FSEL_PER_WORD + i];
               end
            end
         end
         case (idx)
            WORD_LEV0, WORD_LEV1:       read_data = pins_to_word(access.pad_levels, hi);
            WORD_PUD:                   read_data = {30'h0, pud_ff};
            WORD_PUDCLK0, WORD_PUDCLK1: read_data = pins_to_word(pclk_ff, hi);
            default: ;
         endcase
      end
   end

   // Pin status after the access
   always_comb begin
      status.drive = latch_in;
      for (int p = 0; p < PIN_COUNT; p++) begin
         status.output_enable[p] = (func_in[p] == FSEL_OUTPUT);
         status.pull_up[p]       = (pull_in[p] == PULL_UP);
         status.pull_dn[p]       = (pull_in[p] == PULL_DN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PIN_COUNT; p++) begin
            func_ff[p] <= '0;
            pull_ff[p] <= PULL_OFF;
         end
         latch_ff <= '0;
         pclk_ff  <= '0;
         pud_ff   <= PULL_OFF;
      end else begin
         func_ff  <= func_in;
         pull_ff  <= pull_in;
         latch_ff <= latch_in;
         pclk_ff  <= pclk_in;
         pud_ff   <= pud_in;
      end
   end

`ifndef ASSERT_OFF
   a_state_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      !enable |=> (latch_ff == $past(latch_ff)) && (pclk_ff == $past(pclk_ff)))
      else $error("pin state changed without an access");

   a_pull_exclusive: assert property (@(posedge clock) disable iff (reset)
      (status.pull_up & status.pull_dn) == '0)
      else $error("pull-up and pull-down both enabled");

   a_pclk_rise_only: assert property (@(posedge clock) disable iff (reset)
      (wr && ((idx == WORD_SET0) || (idx == WORD_CLR0))) |=> pclk_ff == $past(pclk_ff))
      else $error("pull clock changed on a latch write");
`endif

endmodule

// ----- rtl/gpio_pin_controller_core.sv -----
// ----------------------------------------------------------------------------
// gpio_pin_controller_core
// 54-pin GPIO controller behind 32-bit word registers. Each request beat is
// one bus read or write at a word offset together with the sampled pad
// levels; each response beat returns the read word (zero for a write) and the
// pin drive, output enable and pull enables as they stand after that access.
// One request beat is taken every clock cycle unless the request side stalls.
// A taken beat is held in the input register; once the response register is
// free or being taken, the register-file update loads the response register
// from it, and the response leaves from there. While a response
// waits to be taken, the input register still takes one more request beat;
// after that the request side stalls until the response is taken.
// ----------------------------------------------------------------------------
module gpio_pin_controller_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_op,
   input  logic [5:0]                     req_word_index,
   input  logic [31:0]                    req_write_data,
   input  logic [gpc_pkg::PIN_COUNT-1:0]  req_pad_levels,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [31:0]                    rsp_read_data,
   output logic [gpc_pkg::PIN_COUNT-1:0]  rsp_pin_drive,
   output logic [gpc_pkg::PIN_COUNT-1:0]  rsp_pin_output_enable,
   output logic [gpc_pkg::PIN_COUNT-1:0]  rsp_pull_up_enable,
   output logic [gpc_pkg::PIN_COUNT-1:0]  rsp_pull_down_enable
);
   import gpc_pkg::*;

   logic           s1_valid_ff, s1_valid_in;
   access_type     s1_req_ff;
   logic           advance;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rd_data;
   pin_status_type status;
   logic [31:0]    rsp_data_ff;
   pin_status_type rsp_status_ff;

   // advance the held beat into the response register when it is free or being taken
   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || advance;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   gpc_reg_file u_reg_file (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .access    (s1_req_ff),
      .read_data (rd_data),
      .status    (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff.op         <= req_op;
         s1_req_ff.word_index <= req_word_index;
         s1_req_ff.write_data <= req_write_data;
         s1_req_ff.pad_levels <= req_pad_levels;
      end
      if (advance) begin
         rsp_data_ff   <= rd_data;
         rsp_status_ff <= status;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_data         = rsp_data_ff;
   assign rsp_pin_drive         = rsp_status_ff.drive;
   assign rsp_pin_output_enable = rsp_status_ff.output_enable;
   assign rsp_pull_up_enable    = rsp_status_ff.pull_up;
   assign rsp_pull_down_enable  = rsp_status_ff.pull_dn;

`ifndef ASSERT_OFF
   a_write_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && (s1_req_ff.op == OP_WRITE)) |=> rsp_read_data == '0)
      else $error("write beat returned nonzero read data");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff)
      else $error("request stalled with a free stage");

   a_rsp_from_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(advance))
      else $error("response appeared without a request beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !advance)
      else $error("held response overwritten");
`endif

endmodule
